FILE: hdl/days_between_dates_top_macros.svh
// assertion macros for the day-difference block
// no dependencies; included by the top level only
`ifndef DAYS_BETWEEN_DATES_TOP_MACROS_SVH
`define DAYS_BETWEEN_DATES_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// clocked check, masked while reset is held
`define DBD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check with no reset masking
`define DBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/dbd_pkg.sv
// shared types, constants and calendar tables for the day-difference block
// no dependencies
package dbd_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int DAYS_W = 22;
    localparam int NUM_W  = 23;
    localparam int LT_W   = 12;
    localparam int PART_W = 13;

    localparam int MAX_YEAR = 9999;
    localparam int NSTAGES  = 5;

    // floor(n / 25) = (n * RECIP_25) >> RECIP_SHIFT, exact for n below 4096
    localparam logic [11:0] RECIP_25    = 12'd2622;
    localparam int          RECIP_SHIFT = 16;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
    localparam logic [4:0] FEB_LEAP_LEN  = 5'd29;

    localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MON_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MON_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MON_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MON_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MON_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MON_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MON_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MON_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MON_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

    // replacement date for an invalid input
    localparam int                SUB_YEAR_INT  = 2000;
    localparam logic [DAY_W-1:0]  SUB_DAY       = 5'd1;
    localparam logic [MON_W-1:0]  SUB_MONTH     = MONTH_JAN;
    localparam logic [YEAR_W-1:0] SUB_YEAR      = YEAR_W'(SUB_YEAR_INT);
    localparam int SUB_LEAP_INT = (SUB_YEAR_INT - 1) / 4 - (SUB_YEAR_INT - 1) / 100
                                + (SUB_YEAR_INT - 1) / 400;
    localparam logic [LT_W-1:0]   SUB_LEAP_TERM = LT_W'(SUB_LEAP_INT);

    typedef struct packed {
        logic [DAY_W-1:0]  day_a;
        logic [MON_W-1:0]  month_a;
        logic [YEAR_W-1:0] year_a;
        logic [DAY_W-1:0]  day_b;
        logic [MON_W-1:0]  month_b;
        logic [YEAR_W-1:0] year_b;
    } t_dbd_in;

    typedef struct packed {
        logic [DAYS_W-1:0] days_apart;
        logic              first_invalid;
        logic              second_invalid;
    } t_dbd_out;

    // per-stage load enables, last stage in the top bit
    typedef struct packed {
        logic out;
        logic sum;
        logic mul;
        logic leap;
        logic check;
    } t_stage_en;

    // non-leap month length, zero for codes that are not a month
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_JAN: len = 5'd31;
            MONTH_FEB: len = 5'd28;
            MONTH_MAR: len = 5'd31;
            MONTH_APR: len = 5'd30;
            MONTH_MAY: len = 5'd31;
            MONTH_JUN: len = 5'd30;
            MONTH_JUL: len = 5'd31;
            MONTH_AUG: len = 5'd31;
            MONTH_SEP: len = 5'd30;
            MONTH_OCT: len = 5'd31;
            MONTH_NOV: len = 5'd30;
            MONTH_DEC: len = 5'd31;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // cumulative days of the months before, non-leap
    function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
        logic [8:0] cum;
        case (m)
            MONTH_JAN: cum = 9'd0;
            MONTH_FEB: cum = 9'd31;
            MONTH_MAR: cum = 9'd59;
            MONTH_APR: cum = 9'd90;
            MONTH_MAY: cum = 9'd120;
            MONTH_JUN: cum = 9'd151;
            MONTH_JUL: cum = 9'd181;
            MONTH_AUG: cum = 9'd212;
            MONTH_SEP: cum = 9'd243;
            MONTH_OCT: cum = 9'd273;
            MONTH_NOV: cum = 9'd304;
            MONTH_DEC: cum = 9'd334;
            default:   cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

FILE: hdl/days_between_dates_top.sv
// top level of the day-difference block: valid pipeline and stage instances
// depends on dbd_pkg, dbd_date_unit, dbd_diff_out and the assertion macro header
//
// Usage:
//   Input channel i_valid / o_ready carries one date pair (t_dbd_in) per
//   transaction. Output channel o_valid / i_ready returns one t_dbd_out per
//   input transaction: the absolute day difference and one flag per date
//   that was invalid and replaced by 2000-01-01.
//   From input acceptance to o_valid a transaction passes the range check,
//   leap test with reciprocal /100 and /400, year multiply, day-number sum,
//   then difference and saturation into the output register.
//   Throughput is one transaction per cycle while the receiver takes results;
//   the five register stages each hold one pair and a stage loads whenever
//   it is empty or the stage after it moves on.
//   When the receiver stalls, results back up stage by stage; o_ready falls
//   only once all five stages hold data, so empty slots keep taking input.
//   Synchronous active-low reset empties the pipeline; no result is lost
//   or repeated across a stall.
`include "days_between_dates_top_macros.svh"

module days_between_dates_top import dbd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dbd_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_dbd_out o_data
);

    logic [NSTAGES-1:0] r_vld;
    logic [NSTAGES-1:0] n_vld;
    logic [NSTAGES-1:0] w_adv;
    t_stage_en          w_en;

    logic [NUM_W-1:0] w_num_a;
    logic [NUM_W-1:0] w_num_b;
    logic             w_bad_a;
    logic             w_bad_b;

    // a stage may load when it is empty or its contents move on
    always_comb begin
        w_adv[NSTAGES-1] = !r_vld[NSTAGES-1] || i_ready;
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign w_en = t_stage_en'(w_adv);

    always_comb begin
        n_vld[0] = w_adv[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NSTAGES; k++) begin
            n_vld[k] = w_adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    dbd_date_unit u_date_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_day   (i_data.day_a),
        .i_month (i_data.month_a),
        .i_year  (i_data.year_a),
        .o_num   (w_num_a),
        .o_bad   (w_bad_a)
    );

    dbd_date_unit u_date_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_day   (i_data.day_b),
        .i_month (i_data.month_b),
        .i_year  (i_data.year_b),
        .o_num   (w_num_b),
        .o_bad   (w_bad_b)
    );

    dbd_diff_out u_diff (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num_a (w_num_a),
        .i_num_b (w_num_b),
        .i_bad_a (w_bad_a),
        .i_bad_b (w_bad_b),
        .o_data  (o_data)
    );

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[NSTAGES-1];

    `DBD_ASSERT(a_accept_loads, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0], "accepted transaction not captured in first stage")
    `DBD_ASSERT(a_full_blocks, i_clk, i_rst_n, (($countones(r_vld) == NSTAGES) && !i_ready) |-> !o_ready, "input taken while pipeline full and stalled")
    `DBD_ASSERT(a_sum_hold, i_clk, i_rst_n, (r_vld[3] && !w_en.sum) |=> r_vld[3], "stalled sum stage dropped its transaction")
    `DBD_ASSERT_ALWAYS(a_both_bad_zero, i_clk, (i_rst_n && o_valid && o_data.first_invalid && o_data.second_invalid) |-> (o_data.days_apart == '0), "two replaced dates must be zero days apart")

endmodule

FILE: hdl/dbd_date_unit.sv
// four-stage day-number pipeline for one date: range check, leap test, multiply, sum
// depends on dbd_pkg
module dbd_date_unit import dbd_pkg::*; (
    input  logic              i_clk,
    input  t_stage_en         i_en,
    input  logic [DAY_W-1:0]  i_day,
    input  logic [MON_W-1:0]  i_month,
    input  logic [YEAR_W-1:0] i_year,
    output logic [NUM_W-1:0]  o_num,
    output logic              o_bad
);

    // stage 1: coarse range checks and reciprocal products for /100 and /400
    logic [DAY_W-1:0]  r1_d;
    logic [MON_W-1:0]  r1_m;
    logic [YEAR_W-1:0] r1_y;
    logic [23:0]       r1_p4;
    logic [21:0]       r1_p16;
    logic              r1_rng_ok;
    logic [DAY_W-1:0]  r1_len;

    logic w_rng_ok;
    assign w_rng_ok = (i_year != '0) && (32'(i_year) <= 32'(MAX_YEAR))
                      && (i_month inside {[MONTH_JAN:MONTH_DEC]}) && (i_day != '0);

    always_ff @(posedge i_clk) begin
        if (i_en.check) begin
            r1_d      <= i_day;
            r1_m      <= i_month;
            r1_y      <= i_year;
            r1_p4     <= 24'(i_year[YEAR_W-1:2]) * 24'(RECIP_25);
            r1_p16    <= 22'(i_year[YEAR_W-1:4]) * 22'(RECIP_25);
            r1_rng_ok <= w_rng_ok;
            r1_len    <= month_len(i_month);
        end
    end

    // stage 2: leap test, day check, substitution and leap-day count
    logic [DAY_W-1:0]  r2_d;
    logic [MON_W-1:0]  r2_m;
    logic [YEAR_W-1:0] r2_y;
    logic [LT_W-1:0]   r2_lt;
    logic              r2_bad;

    logic [7:0]        w_q100;
    logic [5:0]        w_q400;
    logic              w_m4;
    logic              w_m100;
    logic              w_m400;
    logic              w_leap;
    logic [DAY_W-1:0]  w_len;
    logic              w_ok;
    logic [LT_W-1:0]   w_lt;

    always_comb begin
        w_q100 = r1_p4[RECIP_SHIFT +: 8];
        w_q400 = r1_p16[RECIP_SHIFT +: 6];
        w_m4   = (r1_y[1:0] == 2'b00);
        w_m100 = ((YEAR_W'(w_q100) * YEAR_W'(100)) == r1_y);
        w_m400 = ((YEAR_W'(w_q400) * YEAR_W'(400)) == r1_y);
        w_leap = w_m4 && (!w_m100 || w_m400);
        w_len  = ((r1_m == MONTH_FEB) && w_leap) ? FEB_LEAP_LEN : r1_len;
        w_ok   = r1_rng_ok && (r1_d <= w_len);
        // january and february count leap days up to the year before
        w_lt   = LT_W'(r1_y[YEAR_W-1:2]) - LT_W'(w_q100) + LT_W'(w_q400)
                 - LT_W'((r1_m <= MONTH_FEB) && w_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.leap) begin
            r2_bad <= !w_ok;
            if (w_ok) begin
                r2_d  <= r1_d;
                r2_m  <= r1_m;
                r2_y  <= r1_y;
                r2_lt <= w_lt;
            end else begin
                r2_d  <= SUB_DAY;
                r2_m  <= SUB_MONTH;
                r2_y  <= SUB_YEAR;
                r2_lt <= SUB_LEAP_TERM;
            end
        end
    end

    // stage 3: year times 365 and the small terms
    logic [NUM_W-1:0]  r3_py;
    logic [PART_W-1:0] r3_part;
    logic              r3_bad;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r3_py   <= NUM_W'(r2_y) * NUM_W'(DAYS_PER_YEAR);
            r3_part <= PART_W'(r2_d) + PART_W'(days_before(r2_m)) + PART_W'(r2_lt);
            r3_bad  <= r2_bad;
        end
    end

    // stage 4: day number
    logic [NUM_W-1:0] r4_num;
    logic             r4_bad;

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r4_num <= r3_py + NUM_W'(r3_part);
            r4_bad <= r3_bad;
        end
    end

    assign o_num = r4_num;
    assign o_bad = r4_bad;

endmodule

FILE: hdl/dbd_diff_out.sv
// output stage: absolute difference of two day numbers, saturated, into the result register
// depends on dbd_pkg
module dbd_diff_out import dbd_pkg::*; (
    input  logic             i_clk,
    input  t_stage_en        i_en,
    input  logic [NUM_W-1:0] i_num_a,
    input  logic [NUM_W-1:0] i_num_b,
    input  logic             i_bad_a,
    input  logic             i_bad_b,
    output t_dbd_out         o_data
);

    t_dbd_out          r_data;
    logic [NUM_W-1:0]  w_diff;
    logic [DAYS_W-1:0] w_sat;

    always_comb begin
        w_diff = (i_num_a >= i_num_b) ? (i_num_a - i_num_b) : (i_num_b - i_num_a);
        // clamp anything beyond the result field
        w_sat  = (w_diff > NUM_W'({DAYS_W{1'b1}})) ? {DAYS_W{1'b1}} : w_diff[DAYS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_data.days_apart     <= w_sat;
            r_data.first_invalid  <= i_bad_a;
            r_data.second_invalid <= i_bad_b;
        end
    end

    assign o_data = r_data;

endmodule
